// File: rtl/rmfw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmfw_pkg
// shared types and constants of the recursive lock with a fifo of waiters
// ----------------------------------------------------------------------------
package rmfw_pkg;

  localparam int TidW        = 8;
  localparam int ThreadCount = 256;
  localparam int WaitDepth   = 16;
  localparam int DepthW      = $clog2(WaitDepth);
  localparam int FillW       = $clog2(WaitDepth + 1);
  localparam int CountW      = 8;
  localparam int CountMax    = 255;
  localparam int StatusW     = 4;

  typedef enum logic [StatusW-1:0] {
    StatGranted  = 4'd0,
    StatNested   = 4'd1,
    StatQueued   = 4'd2,
    StatNestRel  = 4'd3,
    StatFreed    = 4'd4,
    StatHandoff  = 4'd5,
    StatBadRel   = 4'd6,
    StatWaiting  = 4'd7,
    StatFull     = 4'd8
  } status_e;

  typedef enum logic {
    ReqAcquire = 1'b0,
    ReqRelease = 1'b1
  } req_e;

  typedef enum logic {
    StIdle = 1'b0,
    StExec = 1'b1
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

endpackage
`default_nettype wire

// File: rtl/recursive_mutex_fifo_waiters_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// recursive_mutex_fifo_waiters_core
// recursive lock with nest count and a fifo of waiting threads
// ----------------------------------------------------------------------------
// Each item is taken when start is high and busy is low, and passes through
// a capture cycle, then an execute cycle in which the lock state, waiter
// fifo and waiting marks are updated; no new item is taken until the execute
// cycle is over. The waiter fifo head is read from memory with a registered
// read during the capture cycle. Exactly one result per item appears on the
// result ports for one cycle with result_valid_o high, the cycle after the
// execute cycle; the receiver cannot stall and must take it.
module recursive_mutex_fifo_waiters_core
  import rmfw_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              req_type_i,
  input  wire logic [TidW-1:0]   thread_id_i,
  output logic                   result_valid_o,
  output logic [StatusW-1:0]     status_o,
  output logic [TidW-1:0]        handoff_thread_o,
  output logic [CountW-1:0]      nest_count_o
);

  ctrl_cmd_t cmd;

  rmfw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  rmfw_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .req_type_i       (req_type_i),
    .thread_id_i      (thread_id_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .handoff_thread_o (handoff_thread_o),
    .nest_count_o     (nest_count_o)
  );

endmodule
`default_nettype wire

// File: rtl/rmfw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmfw_ctrl
// sequencer: takes one item, runs its execute cycle, then returns to idle
// ----------------------------------------------------------------------------
module rmfw_ctrl
  import rmfw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output ctrl_cmd_t       cmd_o,
  output logic            busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b0;
    case (state_q)
      StIdle: begin
        cmd_o.capture = start_i;
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        busy_o     = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/rmfw_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmfw_dp
// lock state, waiter fifo memory, waiting marks and result registers
// ----------------------------------------------------------------------------
module rmfw_dp
  import rmfw_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctrl_cmd_t         cmd_i,
  input  wire logic              req_type_i,
  input  wire logic [TidW-1:0]   thread_id_i,
  output logic                   result_valid_o,
  output logic [StatusW-1:0]     status_o,
  output logic [TidW-1:0]        handoff_thread_o,
  output logic [CountW-1:0]      nest_count_o
);

  logic [TidW-1:0]   mem_q [WaitDepth];
  logic [TidW-1:0]   rd_q;

  logic              req_q;
  logic [TidW-1:0]   tid_q;

  logic              held_q, held_d;
  logic [TidW-1:0]   holder_q, holder_d;
  logic [CountW-1:0] count_q, count_d;
  logic [DepthW-1:0] head_q, head_d;
  logic [DepthW-1:0] tail_q, tail_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [ThreadCount-1:0] mark_q, mark_d;

  logic              valid_q;
  status_e           stat_q, stat_d;
  logic [TidW-1:0]   hand_q, hand_d;
  logic [CountW-1:0] nest_q;

  logic              wr_en;
  logic              fifo_full;
  logic [DepthW-1:0] head_nx, tail_nx;

  assign fifo_full = (fill_q == FillW'(WaitDepth));
  assign head_nx   = (head_q == DepthW'(WaitDepth - 1)) ? '0 : head_q + DepthW'(1);
  assign tail_nx   = (tail_q == DepthW'(WaitDepth - 1)) ? '0 : tail_q + DepthW'(1);

  always_comb begin
    held_d   = held_q;
    holder_d = holder_q;
    count_d  = count_q;
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    mark_d   = mark_q;
    hand_d   = '0;
    wr_en    = 1'b0;
    stat_d   = StatBadRel;
    if (req_q == ReqAcquire) begin
      if (!held_q) begin
        held_d   = 1'b1;
        holder_d = tid_q;
        count_d  = CountW'(1);
        stat_d   = StatGranted;
      end else if (holder_q == tid_q) begin
        if (count_q >= CountW'(CountMax)) begin
          stat_d = StatFull;
        end else begin
          count_d = count_q + CountW'(1);
          stat_d  = StatNested;
        end
      end else if (mark_q[tid_q]) begin
        stat_d = StatWaiting;
      end else if (fifo_full) begin
        stat_d = StatFull;
      end else begin
        wr_en         = 1'b1;
        tail_d        = tail_nx;
        fill_d        = fill_q + FillW'(1);
        mark_d[tid_q] = 1'b1;
        stat_d        = StatQueued;
      end
    end else begin
      if (!held_q || holder_q != tid_q) begin
        stat_d = StatBadRel;
      end else if (count_q > CountW'(1)) begin
        count_d = count_q - CountW'(1);
        stat_d  = StatNestRel;
      end else if (fill_q == '0) begin
        held_d   = 1'b0;
        holder_d = '0;
        count_d  = '0;
        stat_d   = StatFreed;
      end else begin
        head_d       = head_nx;
        fill_d       = fill_q - FillW'(1);
        mark_d[rd_q] = 1'b0;
        holder_d     = rd_q;
        count_d      = CountW'(1);
        hand_d       = rd_q;
        stat_d       = StatHandoff;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem_q[tail_q] <= tid_q;
    end
    rd_q <= mem_q[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      tid_q <= thread_id_i;
    end
    if (cmd_i.exec) begin
      stat_q <= stat_d;
      hand_q <= hand_d;
      nest_q <= held_d ? count_d : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= 1'b0;
      holder_q <= '0;
      count_q  <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      fill_q   <= '0;
      mark_q   <= '0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= cmd_i.exec;
      if (cmd_i.exec) begin
        held_q   <= held_d;
        holder_q <= holder_d;
        count_q  <= count_d;
        head_q   <= head_d;
        tail_q   <= tail_d;
        fill_q   <= fill_d;
        mark_q   <= mark_d;
      end
    end
  end

  assign result_valid_o   = valid_q;
  assign status_o         = stat_q;
  assign handoff_thread_o = hand_q;
  assign nest_count_o     = nest_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(WaitDepth))
    else $error("waiter fill beyond depth");

  a_held_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q == (count_q != '0))
    else $error("lock held flag and nest count disagree");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> (head_q == tail_q))
    else $error("empty fifo with split pointers");

  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && stat_d == StatHandoff) |=>
      (held_q && count_q == CountW'(1) && !mark_q[holder_q]))
    else $error("handoff left lock in wrong state");

endmodule
`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the recursive lock with a fifo of waiters
// ----------------------------------------------------------------------------
// Acquire and release requests are driven through the start/busy handshake.
// A scoreboard keeps its own copy of the lock state (holder, nest count,
// waiter fifo, waiting marks), works out the expected status, handoff thread
// and nest count of every accepted item, and checks each strobed result
// against the oldest expectation. Directed items cover the id extremes and
// every status but StatFull. Two dedicated phases then fill the waiter fifo
// and drive the nest count to its ceiling. Random sequences follow, mostly
// holder releases and acquires from a small set of threads, mixed with
// noise, with random gaps at the sender.
// ----------------------------------------------------------------------------
module tb;
  import rmfw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit  = 2000;
  localparam int RandomItems = 40;
  localparam int TailCycles  = 12;

  typedef struct packed {
    status_e           status;
    logic [TidW-1:0]   handoff;
    logic [CountW-1:0] count;
  } lock_result_t;

  class lock_scoreboard;
    bit              held;
    logic [TidW-1:0] owner;
    int unsigned     nest_level;
    logic [TidW-1:0] waiters[$];
    bit              is_waiting[ThreadCount];
    lock_result_t    expected_q[$];
    int unsigned     errors;

    function new();
      held = 1'b0;
      owner = '0;
      nest_level = 0;
      errors = 0;
      foreach (is_waiting[k]) is_waiting[k] = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_request(req_e req, logic [TidW-1:0] tid);
      lock_result_t r;
      r.handoff = '0;
      if (req == ReqAcquire) begin
        if (!held) begin
          held = 1'b1;
          owner = tid;
          nest_level = 1;
          r.status = StatGranted;
        end else if (owner == tid) begin
          if (nest_level >= CountMax) begin
            r.status = StatFull;
          end else begin
            nest_level++;
            r.status = StatNested;
          end
        end else if (is_waiting[tid]) begin
          r.status = StatWaiting;
        end else if (waiters.size() >= WaitDepth) begin
          r.status = StatFull;
        end else begin
          waiters.push_back(tid);
          is_waiting[tid] = 1'b1;
          r.status = StatQueued;
        end
      end else begin
        if (!held || owner != tid) begin
          r.status = StatBadRel;
        end else if (nest_level > 1) begin
          nest_level--;
          r.status = StatNestRel;
        end else if (waiters.size() == 0) begin
          held = 1'b0;
          owner = '0;
          nest_level = 0;
          r.status = StatFreed;
        end else begin
          owner = waiters.pop_front();
          is_waiting[owner] = 1'b0;
          nest_level = 1;
          r.handoff = owner;
          r.status = StatHandoff;
        end
      end
      r.count = held ? nest_level[CountW-1:0] : '0;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 60) $display("%0t ns: mismatch: %s", $realtime, msg);
    endtask

    task check_result(logic [StatusW-1:0] status, logic [TidW-1:0] handoff,
                      logic [CountW-1:0] count);
      lock_result_t r;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with no item pending, status %0d", status));
      end else begin
        r = expected_q.pop_front();
        if (status !== r.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, r.status));
        if (handoff !== r.handoff)
          report_mismatch($sformatf("handoff thread %0d, expected %0d", handoff,
                                    r.handoff));
        if (count !== r.count)
          report_mismatch($sformatf("nest count %0d, expected %0d", count, r.count));
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                req_type_i;
  logic [TidW-1:0]     thread_id_i;
  logic                result_valid_o;
  logic [StatusW-1:0]  status_o;
  logic [TidW-1:0]     handoff_thread_o;
  logic [CountW-1:0]   nest_count_o;

  lock_scoreboard sb;
  int unsigned    idle_cycles;

  recursive_mutex_fifo_waiters_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .thread_id_i      (thread_id_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .handoff_thread_o (handoff_thread_o),
    .nest_count_o     (nest_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1)
      sb.check_result(status_o, handoff_thread_o, nest_count_o);
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((start && busy === 1'b0) || result_valid_o === 1'b1) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(req_e req, logic [TidW-1:0] tid);
    bit taken;
    taken = 1'b0;
    start = 1'b1;
    req_type_i = req;
    thread_id_i = tid;
    while (!taken) begin
      @(posedge clk_i);
      taken = (busy === 1'b0);
    end
    sb.note_request(req, tid);
    @(negedge clk_i);
  endtask

  task automatic rest(int unsigned cycles);
    start = 1'b0;
    req_type_i = 1'($urandom_range(1));
    thread_id_i = TidW'($urandom_range(255));
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic release_all();
    while (sb.held) send_request(ReqRelease, sb.owner);
  endtask

  function automatic logic [TidW-1:0] pick_thread();
    logic [TidW-1:0] tid;
    if ($urandom_range(3) == 0) begin
      tid = TidW'($urandom_range(255));
    end else begin
      case ($urandom_range(7))
        0: tid = 8'd0;
        1: tid = 8'd1;
        2: tid = 8'd2;
        3: tid = 8'd3;
        4: tid = 8'd127;
        5: tid = 8'd128;
        6: tid = 8'd254;
        default: tid = 8'd255;
      endcase
    end
    return tid;
  endfunction

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 38 && sb.held)
      send_request(ReqRelease, sb.owner);
    else if (pick < 78)
      send_request(ReqAcquire, pick_thread());
    else if (pick < 88 && sb.held)
      send_request(ReqAcquire, sb.owner);
    else
      send_request(ReqRelease, pick_thread());
  endtask

  initial begin
    logic [TidW-1:0] next_id;
    sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    req_type_i = ReqAcquire;
    thread_id_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed items cover every status but StatFull, id extremes and alternating bit patterns
    send_request(ReqAcquire, 8'd0);
    send_request(ReqAcquire, 8'd0);
    send_request(ReqRelease, 8'd0);
    send_request(ReqRelease, 8'd255);
    send_request(ReqAcquire, 8'd255);
    send_request(ReqAcquire, 8'd255);
    send_request(ReqAcquire, 8'd170);
    send_request(ReqRelease, 8'd0);
    send_request(ReqRelease, 8'd255);
    send_request(ReqRelease, 8'd170);
    send_request(ReqRelease, 8'd170);
    send_request(ReqAcquire, 8'd85);
    send_request(ReqAcquire, 8'd85);
    send_request(ReqRelease, 8'd85);
    send_request(ReqRelease, 8'd85);
    drain_results();

    // waiter fifo to full, a repeat wait, then everything handed back
    send_request(ReqAcquire, 8'd40);
    next_id = 8'd100;
    while (sb.waiters.size() < WaitDepth) begin
      send_request(ReqAcquire, next_id);
      next_id++;
    end
    send_request(ReqAcquire, next_id);
    send_request(ReqAcquire, 8'd100);
    send_request(ReqAcquire, 8'd200);
    release_all();
    drain_results();

    // nest count up to its ceiling and past it
    while (!(sb.held && sb.nest_level == CountMax)) begin
      if (sb.held) send_request(ReqAcquire, sb.owner);
      else send_request(ReqAcquire, 8'd77);
      if ($urandom_range(99) < 26) rest($urandom_range(1, 3));
    end
    send_request(ReqAcquire, sb.owner);
    send_request(ReqAcquire, 8'd12);
    send_request(ReqAcquire, sb.owner);
    while (sb.held) begin
      if ($urandom_range(99) < 26) rest($urandom_range(1, 3));
      send_request(ReqRelease, sb.owner);
    end
    drain_results();

    for (int i = 0; i < RandomItems; i++) begin
      if ($urandom_range(99) < 26)
        rest($urandom_range(1, 5));
      random_item();
      if (i % 20 == 19) drain_results();
    end

    drain_results();
    repeat (TailCycles) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
